[rtl/core/one_way_elevator_request_scheduler_top_defines.svh]
// Assertion macros for the elevator request scheduler.
`ifndef ONE_WAY_ELEVATOR_REQUEST_SCHEDULER_TOP_DEFINES_SVH
`define ONE_WAY_ELEVATOR_REQUEST_SCHEDULER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define OWE_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define OWE_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define OWE_ASSERT_IMPL(label, clk, rst, prop, msg)
`define OWE_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

[rtl/core/oweers_pkg.sv]
// Shared types and constants for the elevator request scheduler.
package oweers_pkg;
   localparam int QueueDepth = 32;
   localparam int SectorBits = 48;
   localparam int TagBits    = 16;
   localparam int IdxBits    = $clog2(QueueDepth);
   localparam int CntBits    = $clog2(QueueDepth + 1);
   localparam int EntryBits  = SectorBits + TagBits;

   typedef enum logic [1:0] {
      MODE_ENQ  = 2'd0,
      MODE_PEEK = 2'd1,
      MODE_POP  = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_SCAN,
      ST_MOVE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [SectorBits-1:0] sector;
      logic [TagBits-1:0]    tag;
   } entry_type;

   typedef struct packed {
      logic                  found;
      logic [SectorBits-1:0] head_sector;
      logic [TagBits-1:0]    head_tag;
      logic                  rejected;
      logic [31:0]           total_scheduled;
   } result_type;
endpackage

[rtl/core/one_way_elevator_request_scheduler_top.sv]
// Top level of the elevator request scheduler.
// channel | dir | payload
// req     | in  | tdata: mode[1:0], sector[49:2], request_tag[65:50], pad to 72
// rsp     | out | tdata: found[0], head_sector[48:1], head_tag[64:49], rejected[65],
//         |     |        total_scheduled[97:66], pad to 104
// Peek, unused mode and a rejected enqueue only read the head and load the result.
// Enqueue reads the head, shifts larger entries up one per step and writes the new one;
// pop reads the head and shifts the entries left behind down one per step.
// Reset is synchronous and clears counts, role and the output register.
// A stalled result holds the next item in its last state; no transfer is taken meanwhile.
module one_way_elevator_request_scheduler_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,   // mode, sector, request_tag
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata    // found, head_sector, head_tag, rejected, total_scheduled
);
   import oweers_pkg::*;

   result_type res;

   oweers_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_mode(req_tdata[1:0]),
      .req_sector(req_tdata[49:2]),
      .req_tag(req_tdata[65:50]),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_result(res));

   assign rsp_tdata = {6'd0, res.total_scheduled, res.rejected, res.head_tag,
                       res.head_sector, res.found};
endmodule

[rtl/core/oweers_ram.sv]
// One-read one-write RAM with registered read data.
module oweers_ram #(
   parameter int Depth = 32,
   parameter int Width = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/core/oweers_ctrl.sv]
// Sequencer: head read, sorted insert with upward shift, pop with downward shift, result register.
`include "one_way_elevator_request_scheduler_top_defines.svh"
module oweers_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [1:0]                     req_mode,
   input  logic [oweers_pkg::SectorBits-1:0] req_sector,
   input  logic [oweers_pkg::TagBits-1:0] req_tag,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output oweers_pkg::result_type         rsp_result
);
   import oweers_pkg::*;

   state_type state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   entry_type new_ff, new_in;
   logic [CntBits-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic cur_b_ff, cur_b_in, tgt_b_ff, tgt_b_in;
   logic [31:0] acc_ff, acc_in;
   logic [CntBits-1:0] pos_ff, pos_in;
   result_type res_ff, res_in, out_ff, out_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic accept, load_out;
   logic we, we_a, we_b;
   logic [IdxBits-1:0] wa, ra;
   entry_type wd, rd_a, rd_b, rd_t, rd_c;
   logic [CntBits-1:0] cnt_c, cnt_t, cnt_h;
   logic tgt_h;

   oweers_ram #(.Depth(QueueDepth), .Width(EntryBits)) u_ram_a (
      .clock(clock), .wr_en(we_a), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd_a));
   oweers_ram #(.Depth(QueueDepth), .Width(EntryBits)) u_ram_b (
      .clock(clock), .wr_en(we_b), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd_b));

   assign cnt_c   = cur_b_ff ? cnt_b_ff : cnt_a_ff;
   assign cnt_t   = tgt_b_ff ? cnt_b_ff : cnt_a_ff;
   assign rd_t    = tgt_b_ff ? rd_b : rd_a;
   assign rd_c    = cur_b_ff ? rd_b : rd_a;
   assign tgt_h   = (cnt_c != '0 && new_ff.sector < rd_c.sector) ? ~cur_b_ff : cur_b_ff;
   assign cnt_h   = tgt_h ? cnt_b_ff : cnt_a_ff;
   assign we_a    = we && !tgt_b_ff;
   assign we_b    = we && tgt_b_ff;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load_out   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = out_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_HEAD;
         ST_HEAD: begin
            if (mode_ff == MODE_ENQ) begin
               state_in = (cnt_h == CntBits'(QueueDepth)) ? ST_DONE : ST_SCAN;
            end else if (mode_ff == MODE_POP && cnt_c > CntBits'(1)) begin
               state_in = ST_MOVE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: if (pos_ff == '0 || rd_t.sector <= new_ff.sector) state_in = ST_DONE;
         ST_MOVE: if (pos_ff + CntBits'(1) == cnt_t) state_in = ST_DONE;
         ST_DONE: if (load_out) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mode_in      = mode_ff;
      new_in       = new_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      cur_b_in     = cur_b_ff;
      tgt_b_in     = tgt_b_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      we = 1'b0;
      wa = '0;
      wd = new_ff;
      ra = '0;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // swap roles when current queue is empty at transfer, unless the mode is unused
            if (accept) begin
               mode_in = req_mode;
               new_in  = '{sector: req_sector, tag: req_tag};
               if (req_mode != MODE_NONE && cnt_c == '0) cur_b_in = ~cur_b_ff;
            end
         end
         ST_HEAD: begin
            res_in = '0;
            res_in.total_scheduled = acc_ff;
            tgt_b_in = cur_b_ff;
            pos_in = '0;
            ra = IdxBits'(1);
            if (mode_ff == MODE_ENQ) begin
               tgt_b_in = tgt_h;
               pos_in = cnt_h;
               ra = IdxBits'(cnt_h - CntBits'(1));
               if (cnt_h == CntBits'(QueueDepth)) res_in.rejected = 1'b1;
            end else if ((mode_ff == MODE_PEEK || mode_ff == MODE_POP) && cnt_c != '0) begin
               res_in.found = 1'b1;
               res_in.head_sector = rd_c.sector;
               res_in.head_tag = rd_c.tag;
               if (mode_ff == MODE_POP) begin
                  if (cur_b_ff) cnt_b_in = cnt_b_ff - CntBits'(1);
                  else cnt_a_in = cnt_a_ff - CntBits'(1);
               end
            end
         end
         ST_SCAN: begin
            // shift larger entries up, drop the new one into the gap
            we = 1'b1;
            wa = pos_ff[IdxBits-1:0];
            ra = IdxBits'(pos_ff - CntBits'(2));
            if (pos_ff != '0 && rd_t.sector > new_ff.sector) begin
               wd = rd_t;
               pos_in = pos_ff - CntBits'(1);
            end else begin
               wd = new_ff;
               acc_in = acc_ff + 32'd1;
               res_in.total_scheduled = acc_ff + 32'd1;
               if (tgt_b_ff) cnt_b_in = cnt_b_ff + CntBits'(1);
               else cnt_a_in = cnt_a_ff + CntBits'(1);
            end
         end
         ST_MOVE: begin
            // shift remaining entries down by one
            we = 1'b1;
            wa = pos_ff[IdxBits-1:0];
            wd = rd_t;
            ra = IdxBits'(pos_ff + CntBits'(2));
            pos_in = pos_ff + CntBits'(1);
         end
         ST_DONE: begin
            if (load_out) begin
               out_in = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= '0;
         new_ff       <= '0;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         cur_b_ff     <= 1'b0;
         tgt_b_ff     <= 1'b0;
         acc_ff       <= '0;
         pos_ff       <= '0;
         res_ff       <= '0;
         out_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         new_ff       <= new_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         cur_b_ff     <= cur_b_in;
         tgt_b_ff     <= tgt_b_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         res_ff       <= res_in;
         out_ff       <= out_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `OWE_ASSERT_IMPL(a_cnt_a_range, clock, reset, cnt_a_ff <= CntBits'(QueueDepth), "queue A count out of range")
   `OWE_ASSERT_IMPL(a_cnt_b_range, clock, reset, cnt_b_ff <= CntBits'(QueueDepth), "queue B count out of range")
   `OWE_ASSERT_IMPL(a_scan_pos, clock, reset, state_ff != ST_SCAN || pos_ff < CntBits'(QueueDepth), "insert position beyond queue")
   `OWE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_result), "result changed while stalled")
endmodule
